// File: rtl/core/tcw_pkg.sv
package tcw_pkg;

	localparam int SCREEN_COLUMNS_DEF = 80;
	localparam int SCREEN_ROWS_DEF    = 25;
	localparam int MARGIN_COLUMNS_DEF = 1;

	localparam int CMD_W  = 3;
	localparam int CHAR_W = 8;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int POS_W  = 11;
	localparam int ATTR_W = 8;
	// set-cursor normalizer: holds col + margin and the row, which grows during the row fold
	localparam int NORM_W = 9;

	localparam logic [CMD_W-1:0] CMD_DRAW   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SETCUR = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_NOP       = 8'hFC;
	localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
	localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;

	typedef enum logic [3:0] {
		OP_PRINT,
		OP_NEWLINE,
		OP_BKSP,
		OP_DNOP,
		OP_CLEAR,
		OP_SETCUR,
		OP_SCROLL,
		OP_READ,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
		logic              rd_ok;
	} item_t;

	typedef struct packed {
		logic init;
	} back_stat_t;

endpackage

// File: rtl/core/tcw_if.sv
interface tcw_in_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::CMD_W-1:0]   cmd;
	logic [tcw_pkg::CHAR_W-1:0]  char_code;
	logic [tcw_pkg::COL_W-1:0]   col;
	logic [tcw_pkg::ROW_W-1:0]   row;

	modport source (output valid, cmd, char_code, col, row, input ready);
	modport sink (input valid, cmd, char_code, col, row, output ready);
endinterface

interface tcw_out_if;
	logic                        valid;
	logic                        ready;
	logic [tcw_pkg::POS_W-1:0]   cursor_position;
	logic                        scrolled;
	logic [tcw_pkg::CHAR_W-1:0]  cell_char;
	logic [tcw_pkg::ATTR_W-1:0]  cell_attribute;

	modport source (output valid, cursor_position, scrolled, cell_char, cell_attribute,
		input ready);
	modport sink (input valid, cursor_position, scrolled, cell_char, cell_attribute,
		output ready);
endinterface

// File: rtl/core/tcw_front.sv
module tcw_front #(
	parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	tcw_in_if.sink              in_ch,
	input  tcw_pkg::back_stat_t stat,
	output tcw_pkg::item_t      q_item,
	output logic                q_valid,
	input  logic                q_ready
);

	tcw_pkg::item_t cls;
	tcw_pkg::item_t fifo_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	always_comb begin
		cls.ch    = in_ch.char_code;
		cls.col   = in_ch.col;
		cls.row   = in_ch.row;
		cls.rd_ok = (int'(in_ch.col) < SCREEN_COLUMNS) && (int'(in_ch.row) < SCREEN_ROWS);
		unique case (in_ch.cmd)
			tcw_pkg::CMD_DRAW: begin
				if (in_ch.char_code == tcw_pkg::CH_NEWLINE) begin
					cls.op = tcw_pkg::OP_NEWLINE;
				end else if (in_ch.char_code == tcw_pkg::CH_BACKSPACE) begin
					cls.op = tcw_pkg::OP_BKSP;
				end else if (in_ch.char_code == tcw_pkg::CH_NOP) begin
					cls.op = tcw_pkg::OP_DNOP;
				end else begin
					cls.op = tcw_pkg::OP_PRINT;
				end
			end
			tcw_pkg::CMD_CLEAR:  cls.op = tcw_pkg::OP_CLEAR;
			tcw_pkg::CMD_SETCUR: cls.op = tcw_pkg::OP_SETCUR;
			tcw_pkg::CMD_SCROLL: cls.op = tcw_pkg::OP_SCROLL;
			tcw_pkg::CMD_READ:   cls.op = tcw_pkg::OP_READ;
			default:             cls.op = tcw_pkg::OP_NONE;
		endcase
	end

	// no transfer while the store is being cleared after reset
	assign in_ch.ready = (cnt_q != 2'd2) && !stat.init;
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = cnt_q != 2'd0;
	assign q_item      = fifo_q[rd_ptr_q];
	assign pop         = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_take_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		stat.init |-> !in_ch.ready) else $error("transfer during init clear");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");
	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> cnt_q == 2'd2) else $error("full queue lost entry");
`endif

endmodule

// File: rtl/core/tcw_back.sv
module tcw_back #(
	parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF,
	parameter int MARGIN_COLUMNS = tcw_pkg::MARGIN_COLUMNS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tcw_pkg::item_t              q_item,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  logic [tcw_pkg::ATTR_W-1:0]  attr,
	output tcw_pkg::back_stat_t         stat,
	tcw_out_if.source                   out_ch
);

	localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int IW    = $clog2(CELLS + MARGIN_COLUMNS + 1);
	localparam int RW    = $clog2(SCREEN_ROWS + 1);
	localparam int CW    = $clog2(SCREEN_COLUMNS);
	localparam int NW    = tcw_pkg::NORM_W;

	localparam logic [IW-1:0] CELLS_I   = IW'(CELLS);
	localparam logic [IW-1:0] LAST_I    = IW'(CELLS - 1);
	localparam logic [IW-1:0] MOVE_LAST = IW'(CELLS - SCREEN_COLUMNS - 1);
	localparam logic [IW-1:0] BOT_HOME  = IW'(CELLS - SCREEN_COLUMNS + MARGIN_COLUMNS);
	localparam logic [IW-1:0] COLS_I    = IW'(SCREEN_COLUMNS);
	localparam logic [IW-1:0] NL_STEP   = IW'(SCREEN_COLUMNS + MARGIN_COLUMNS);
	localparam logic [IW-1:0] MARGIN_I  = IW'(MARGIN_COLUMNS);
	localparam logic [RW-1:0] ROWS_R    = RW'(SCREEN_ROWS);
	localparam logic [RW-1:0] BOT_ROW   = RW'(SCREEN_ROWS - 1);
	localparam logic [CW-1:0] MARGIN_C  = CW'(MARGIN_COLUMNS);
	localparam logic [CW-1:0] WRAP_C    = CW'(SCREEN_COLUMNS - 1);
	localparam logic [NW-1:0] ROWS_N    = NW'(SCREEN_ROWS);
	localparam logic [NW-1:0] COLS_N    = NW'(SCREEN_COLUMNS);
	localparam logic [NW-1:0] MARGIN_N  = NW'(MARGIN_COLUMNS);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CLEAR   = 4'd1;
	localparam logic [3:0] S_DRAW    = 4'd2;
	localparam logic [3:0] S_SETTLE  = 4'd3;
	localparam logic [3:0] S_PUT     = 4'd4;
	localparam logic [3:0] S_SCR_RD  = 4'd5;
	localparam logic [3:0] S_SCR_WR  = 4'd6;
	localparam logic [3:0] S_BLANK   = 4'd7;
	localparam logic [3:0] S_NORM    = 4'd8;
	localparam logic [3:0] S_RD_WAIT = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;

	logic [3:0]                 state_q;
	logic [3:0]                 ret_q;
	logic                       init_q;
	tcw_pkg::item_t             item_q;
	logic [IW-1:0]              cur_q;
	logic [RW-1:0]              row_q;
	logic [CW-1:0]              col_q;
	logic [IW-1:0]              idx_q;
	logic [tcw_pkg::ATTR_W-1:0] clr_attr_q;
	logic                       sc_q;
	logic [7:0]                 rc_q;
	logic [7:0]                 ra_q;
	logic [NW-1:0]              nr_q;
	logic [NW-1:0]              nc_q;
	logic                       out_valid_q;
	logic [tcw_pkg::POS_W-1:0]  out_pos_q;
	logic                       out_sc_q;
	logic [7:0]                 out_rc_q;
	logic [7:0]                 out_ra_q;

	logic [15:0]   mem [CELLS];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata_q;

	assign stat.init = init_q;
	assign q_ready   = (state_q == S_IDLE);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(idx_q);
		mem_wdata = {attr, tcw_pkg::CH_BLANK};
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_item.rd_ok) begin
					mem_raddr = AW'(int'(q_item.row) * SCREEN_COLUMNS + int'(q_item.col));
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = {clr_attr_q, tcw_pkg::CH_BLANK};
			end
			S_SCR_RD: mem_raddr = AW'(idx_q + COLS_I);
			S_SCR_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q;
			end
			S_BLANK: mem_we = 1'b1;
			S_DRAW: begin
				if (row_q != ROWS_R) begin
					if (item_q.op == tcw_pkg::OP_BKSP && col_q > MARGIN_C) begin
						mem_we    = 1'b1;
						mem_waddr = AW'(cur_q - IW'(1));
					end else if (item_q.op == tcw_pkg::OP_PRINT && col_q < WRAP_C) begin
						mem_we    = 1'b1;
						mem_waddr = AW'(cur_q);
						mem_wdata = {attr, item_q.ch};
					end
				end
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(cur_q);
				mem_wdata = {attr, item_q.ch};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ret_q       <= S_DONE;
			init_q      <= 1'b1;
			cur_q       <= MARGIN_I;
			row_q       <= '0;
			col_q       <= MARGIN_C;
			idx_q       <= '0;
			clr_attr_q  <= tcw_pkg::ATTR_RESET;
			sc_q        <= 1'b0;
			rc_q        <= '0;
			ra_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						sc_q   <= 1'b0;
						rc_q   <= '0;
						ra_q   <= '0;
						idx_q  <= '0;
						ret_q  <= S_DONE;
						case (q_item.op)
							tcw_pkg::OP_PRINT, tcw_pkg::OP_NEWLINE,
							tcw_pkg::OP_BKSP, tcw_pkg::OP_DNOP: state_q <= S_DRAW;
							tcw_pkg::OP_CLEAR: begin
								clr_attr_q <= attr;
								state_q    <= S_CLEAR;
							end
							tcw_pkg::OP_SETCUR: begin
								nr_q    <= NW'(q_item.row);
								nc_q    <= NW'(q_item.col) + MARGIN_N;
								state_q <= S_NORM;
							end
							tcw_pkg::OP_SCROLL: begin
								sc_q    <= 1'b1;
								state_q <= S_SCR_RD;
							end
							tcw_pkg::OP_READ: state_q <= q_item.rd_ok ? S_RD_WAIT : S_DONE;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST_I) begin
						cur_q  <= MARGIN_I;
						row_q  <= '0;
						col_q  <= MARGIN_C;
						init_q <= 1'b0;
						state_q <= init_q ? S_IDLE : S_DONE;
					end
				end
				S_DRAW: begin
					if (row_q == ROWS_R) begin
						// at screen end: scroll first, then redo this draw
						sc_q    <= 1'b1;
						cur_q   <= BOT_HOME;
						row_q   <= BOT_ROW;
						col_q   <= MARGIN_C;
						idx_q   <= '0;
						ret_q   <= S_DRAW;
						state_q <= S_SCR_RD;
					end else begin
						state_q <= S_DONE;
						case (item_q.op)
							tcw_pkg::OP_NEWLINE: begin
								cur_q   <= cur_q - IW'(col_q) + NL_STEP;
								row_q   <= row_q + RW'(1);
								col_q   <= MARGIN_C;
								ret_q   <= S_DONE;
								state_q <= S_SETTLE;
							end
							tcw_pkg::OP_BKSP: begin
								if (col_q > MARGIN_C) begin
									cur_q <= cur_q - IW'(1);
									col_q <= col_q - CW'(1);
								end
							end
							tcw_pkg::OP_PRINT: begin
								if (col_q >= WRAP_C) begin
									cur_q   <= cur_q - IW'(col_q) + NL_STEP;
									row_q   <= row_q + RW'(1);
									col_q   <= MARGIN_C;
									ret_q   <= S_PUT;
									state_q <= S_SETTLE;
								end else begin
									cur_q <= cur_q + IW'(1);
									col_q <= col_q + CW'(1);
								end
							end
							default: ;
						endcase
					end
				end
				S_SETTLE: begin
					if (row_q == ROWS_R) begin
						sc_q    <= 1'b1;
						cur_q   <= BOT_HOME;
						row_q   <= BOT_ROW;
						col_q   <= MARGIN_C;
						idx_q   <= '0;
						state_q <= S_SCR_RD;
					end else begin
						state_q <= ret_q;
					end
				end
				S_PUT: begin
					cur_q   <= cur_q + IW'(1);
					col_q   <= col_q + CW'(1);
					state_q <= S_DONE;
				end
				S_SCR_RD: state_q <= S_SCR_WR;
				S_SCR_WR: begin
					idx_q   <= idx_q + IW'(1);
					state_q <= (idx_q == MOVE_LAST) ? S_BLANK : S_SCR_RD;
				end
				S_BLANK: begin
					idx_q <= idx_q + IW'(1);
					if (idx_q == LAST_I) begin
						state_q <= ret_q;
					end
				end
				S_NORM: begin
					if (nr_q > ROWS_N) begin
						cur_q   <= CELLS_I;
						row_q   <= ROWS_R;
						col_q   <= '0;
						state_q <= S_DONE;
					end else if (nc_q >= COLS_N) begin
						nc_q <= nc_q - COLS_N;
						nr_q <= nr_q + NW'(1);
					end else if (nr_q == ROWS_N && nc_q != '0) begin
						cur_q   <= CELLS_I;
						row_q   <= ROWS_R;
						col_q   <= '0;
						state_q <= S_DONE;
					end else begin
						cur_q   <= IW'(int'(nr_q) * SCREEN_COLUMNS + int'(nc_q));
						row_q   <= RW'(nr_q);
						col_q   <= CW'(nc_q);
						state_q <= S_DONE;
					end
				end
				S_RD_WAIT: begin
					rc_q    <= mem_rdata_q[7:0];
					ra_q    <= mem_rdata_q[15:8];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_pos_q   <= tcw_pkg::POS_W'(cur_q);
						out_sc_q    <= sc_q;
						out_rc_q    <= rc_q;
						out_ra_q    <= ra_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.cursor_position = out_pos_q;
	assign out_ch.scrolled        = out_sc_q;
	assign out_ch.cell_char       = out_rc_q;
	assign out_ch.cell_attribute  = out_ra_q;

`ifndef NO_ASSERTIONS
	a_cursor_linear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && row_q != ROWS_R) |->
		int'(cur_q) == int'(row_q) * SCREEN_COLUMNS + int'(col_q))
		else $error("cursor row/col out of step with index");
	a_cursor_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && row_q == ROWS_R) |-> (cur_q == CELLS_I && col_q == '0))
		else $error("past-end cursor malformed");
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> int'(mem_waddr) < CELLS) else $error("store write out of range");
	a_init_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !q_ready) else $error("item taken during init clear");
`endif

endmodule

// File: rtl/core/text_console_writer.sv
// Text console writer: screen store with cursor, wrap, newline, backspace and scroll.
// Each item runs through the back-end sequencer, then waits for the output register;
// a wrapping draw adds settle and put steps; a scroll moves rows up, blanks the last
// row; a clear writes every cell. The back end takes a new item only after the last.
// Reset (arst_n, async low): attribute 0x07, cursor at margin, then a clearing
// pass over all CELLS cells (2000 by default) during which no input transfer occurs.
module text_console_writer #(
	parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF,
	parameter int MARGIN_COLUMNS = tcw_pkg::MARGIN_COLUMNS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tcw_in_if.sink      in_ch,
	tcw_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// register map: text_attribute at byte address 0
	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	tcw_pkg::item_t             q_item;
	logic                       q_valid;
	logic                       q_ready;
	tcw_pkg::back_stat_t        stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {24'd0, attr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			attr_q <= pwdata[7:0];
		end
	end

	// front end: takes transfers, decodes commands, queues them
	tcw_front #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.stat   (stat),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_ready(q_ready)
	);

	// back end: cursor logic, store sweeps for scroll/clear, result register
	tcw_back #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS),
		.MARGIN_COLUMNS(MARGIN_COLUMNS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_item (q_item),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.attr   (attr_q),
		.stat   (stat),
		.out_ch (out_ch)
	);

endmodule
